// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/bole_pkg.sv -----
// Shared types, codes and constants for the bounded ordered list engine.
// No dependencies.
package bole_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int IN_W  = 48;
    localparam int OUT_W = 48;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_REM_FRONT = 3'd3;
    localparam logic [2:0] OP_REM_BACK  = 3'd4;
    localparam logic [2:0] OP_REM_POS   = 3'd5;
    localparam logic [2:0] OP_SEARCH    = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_LATCH    = 4'd1;
    localparam logic [3:0] ACT_DECODE   = 4'd2;
    localparam logic [3:0] ACT_FREE_CAP = 4'd3;
    localparam logic [3:0] ACT_WSTART   = 4'd4;
    localparam logic [3:0] ACT_WALK     = 4'd5;
    localparam logic [3:0] ACT_INS_F    = 4'd6;
    localparam logic [3:0] ACT_INS_B    = 4'd7;
    localparam logic [3:0] ACT_INS_M1   = 4'd8;
    localparam logic [3:0] ACT_INS_M2   = 4'd9;
    localparam logic [3:0] ACT_REM_F    = 4'd10;
    localparam logic [3:0] ACT_RB_RD    = 4'd11;
    localparam logic [3:0] ACT_RB_CAP   = 4'd12;
    localparam logic [3:0] ACT_REM_M    = 4'd13;
    localparam logic [3:0] ACT_LOAD_OUT = 4'd14;

    typedef struct packed {
        logic [3:0] act;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       count_zero;
        logic       full;
        logic       pos_zero;
        logic       pos_eq_count;
        logic       pos_gt_count;
        logic       pos_eq_last;
        logic       walk_done;
        logic       out_free;
    } flags_t;

endpackage

// ----- rtl/bole_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bole_datapath.sv -----
// Datapath: slot memories, free stack, head/tail/count, list walker, output register.
// Depends on bole_pkg and bole_ram.
module bole_datapath
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output flags_t           flags,
    input  logic [IN_W-1:0]  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > 10) ? CW : 10;

    logic [2:0]        op_reg;
    logic [31:0]       val_reg;
    logic [8:0]        pos_reg;
    logic [SW-1:0]     head_reg, tail_reg, s_reg, cur_reg, p1_reg, p2_reg;
    logic [CW-1:0]     count_reg, mark_reg;
    logic [KW-1:0]     k_reg;
    logic              issued_reg, found_reg, out_valid_reg;
    logic [31:0]       removed_reg;
    logic [1:0]        status_reg;
    logic [OUT_W-1:0]  out_data_reg;

    logic [KW-1:0]     count_w, pos_w, walk_len;
    logic [SW-1:0]     cur_w, count_idx, last_idx;
    logic [CW-1:0]     count_m1;

    logic              val_we, nx_we, pv_we, fr_we;
    logic [SW-1:0]     val_raddr, nx_waddr, nx_wdata, pv_waddr, pv_wdata, fr_wdata;
    logic [31:0]       val_rdata;
    logic [SW-1:0]     nx_rdata, pv_rdata, fr_rdata;

    assign count_w   = KW'(count_reg);
    assign pos_w     = KW'(pos_reg);
    assign count_m1  = count_reg - 1'b1;
    assign count_idx = count_reg[SW-1:0];
    assign last_idx  = count_m1[SW-1:0];
    assign cur_w     = issued_reg ? nx_rdata : cur_reg;

    always_comb
    begin
        case (op_reg)
            OP_SEARCH:    walk_len = count_w;
            OP_REM_POS:   walk_len = pos_w + 1'b1;
            OP_REM_FRONT: walk_len = KW'(1);
            default:      walk_len = pos_w;
        endcase
    end

    always_comb
    begin
        flags.op           = op_reg;
        flags.count_zero   = (count_reg == '0);
        flags.full         = (count_w >= KW'(CAPACITY));
        flags.pos_zero     = (pos_reg == '0);
        flags.pos_eq_count = (pos_w == count_w);
        flags.pos_gt_count = (pos_w > count_w);
        flags.pos_eq_last  = (pos_w == count_w - 1'b1);
        flags.walk_done    = (k_reg == walk_len);
        flags.out_free     = !out_valid_reg || out_ready;
    end

    // Memory port steering per action.
    always_comb
    begin
        val_we    = 1'b0;
        nx_we     = 1'b0;
        pv_we     = 1'b0;
        fr_we     = 1'b0;
        nx_waddr  = s_reg;
        nx_wdata  = head_reg;
        pv_waddr  = head_reg;
        pv_wdata  = s_reg;
        fr_wdata  = p1_reg;
        val_raddr = (cmd.act == ACT_RB_RD) ? tail_reg : cur_w;
        case (cmd.act)
            ACT_INS_F:
            begin
                val_we = 1'b1;
                nx_we  = 1'b1;
                pv_we  = 1'b1;
            end
            ACT_INS_B:
            begin
                val_we   = 1'b1;
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = tail_reg;
                nx_wdata = s_reg;
                pv_waddr = s_reg;
                pv_wdata = tail_reg;
            end
            ACT_INS_M1:
            begin
                val_we   = 1'b1;
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_wdata = cur_reg;
                pv_waddr = s_reg;
                pv_wdata = p1_reg;
            end
            ACT_INS_M2:
            begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = p1_reg;
                nx_wdata = s_reg;
                pv_waddr = cur_reg;
                pv_wdata = s_reg;
            end
            ACT_REM_F:
            begin
                fr_we = 1'b1;
            end
            ACT_RB_CAP:
            begin
                fr_we    = 1'b1;
                fr_wdata = tail_reg;
            end
            ACT_REM_M:
            begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                fr_we    = 1'b1;
                nx_waddr = p2_reg;
                nx_wdata = cur_reg;
                pv_waddr = cur_reg;
                pv_wdata = p2_reg;
            end
            default:
            begin
            end
        endcase
    end

    bole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(val_we), .waddr(s_reg), .wdata(val_reg),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    bole_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(cur_w), .rdata(nx_rdata)
    );

    bole_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(tail_reg), .rdata(pv_rdata)
    );

    bole_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
        .clk(clk), .we(fr_we), .waddr(last_idx), .wdata(fr_wdata),
        .raddr(count_idx), .rdata(fr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            mark_reg      <= '0;
            k_reg         <= '0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Free stack entries at or above the mark were never written: their own index stands in for them.
            if (fr_we && (count_reg > mark_reg))
            begin
                mark_reg <= count_reg;
            end
            case (cmd.act)
                ACT_WSTART:
                begin
                    k_reg      <= '0;
                    issued_reg <= 1'b0;
                end
                ACT_WALK:
                begin
                    if (k_reg != walk_len)
                    begin
                        k_reg      <= k_reg + 1'b1;
                        issued_reg <= 1'b1;
                    end
                end
                ACT_INS_F:
                begin
                    head_reg  <= s_reg;
                    if (count_reg == '0)
                    begin
                        tail_reg <= s_reg;
                    end
                    count_reg <= count_reg + 1'b1;
                end
                ACT_INS_B:
                begin
                    tail_reg  <= s_reg;
                    if (count_reg == '0)
                    begin
                        head_reg <= s_reg;
                    end
                    count_reg <= count_reg + 1'b1;
                end
                ACT_INS_M2:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                ACT_REM_F:
                begin
                    count_reg <= count_m1;
                    if (count_m1 == '0)
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        head_reg <= cur_reg;
                    end
                end
                ACT_RB_CAP:
                begin
                    count_reg <= count_m1;
                    if (count_m1 == '0)
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        tail_reg <= pv_rdata;
                    end
                end
                ACT_REM_M:
                begin
                    count_reg <= count_m1;
                end
                default:
                begin
                end
            endcase
            if (cmd.act == ACT_LOAD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            ACT_LATCH:
            begin
                op_reg  <= in_data[2:0];
                val_reg <= in_data[34:3];
                pos_reg <= in_data[43:35];
            end
            ACT_DECODE:
            begin
                status_reg  <= cmd.status;
                removed_reg <= '0;
                found_reg   <= 1'b0;
            end
            ACT_FREE_CAP:
            begin
                s_reg <= (count_reg >= mark_reg) ? count_idx : fr_rdata;
            end
            ACT_WSTART:
            begin
                cur_reg <= head_reg;
            end
            ACT_WALK:
            begin
                cur_reg <= cur_w;
                if (issued_reg && (op_reg == OP_SEARCH) && (val_rdata == val_reg))
                begin
                    found_reg <= 1'b1;
                end
                if (k_reg != walk_len)
                begin
                    p1_reg <= cur_w;
                    p2_reg <= p1_reg;
                end
                else if (op_reg != OP_SEARCH && op_reg != OP_INS_POS)
                begin
                    removed_reg <= val_rdata;
                end
            end
            ACT_RB_CAP:
            begin
                removed_reg <= val_rdata;
            end
            ACT_LOAD_OUT:
            begin
                out_data_reg <= {4'b0, count_w[8:0], found_reg, removed_reg, status_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/bole_ctrl.sv -----
// Controller: sequences each operation through the datapath.
// Depends on bole_pkg.
module bole_ctrl
    import bole_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  flags_t flags,
    output cmd_t   cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_FREE_RD  = 4'd2;
    localparam logic [3:0] S_FREE_CAP = 4'd3;
    localparam logic [3:0] S_WSTART   = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_INS_F    = 4'd6;
    localparam logic [3:0] S_INS_B    = 4'd7;
    localparam logic [3:0] S_INS_M1   = 4'd8;
    localparam logic [3:0] S_INS_M2   = 4'd9;
    localparam logic [3:0] S_REM_F    = 4'd10;
    localparam logic [3:0] S_RB_RD    = 4'd11;
    localparam logic [3:0] S_RB_CAP   = 4'd12;
    localparam logic [3:0] S_REM_M    = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    localparam logic [1:0] K_FRONT = 2'd0;
    localparam logic [1:0] K_BACK  = 2'd1;
    localparam logic [1:0] K_MID   = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.act    = ACT_NONE;
        cmd.status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = ACT_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.act    = ACT_DECODE;
                state_next = S_DONE;
                case (flags.op)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
                    begin
                        if (flags.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else if (flags.op == OP_INS_FRONT ||
                                 (flags.op == OP_INS_POS && flags.pos_zero))
                        begin
                            kind_next  = K_FRONT;
                            state_next = S_FREE_RD;
                        end
                        else if (flags.op == OP_INS_BACK || flags.pos_eq_count)
                        begin
                            kind_next  = K_BACK;
                            state_next = S_FREE_RD;
                        end
                        else if (flags.pos_gt_count)
                        begin
                            cmd.status = ST_BADPOS;
                        end
                        else
                        begin
                            kind_next  = K_MID;
                            state_next = S_FREE_RD;
                        end
                    end
                    OP_REM_FRONT, OP_REM_BACK, OP_REM_POS:
                    begin
                        if (flags.count_zero)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else if (flags.op == OP_REM_FRONT ||
                                 (flags.op == OP_REM_POS && flags.pos_zero))
                        begin
                            kind_next  = K_FRONT;
                            state_next = S_WSTART;
                        end
                        else if (flags.op == OP_REM_BACK || flags.pos_eq_last)
                        begin
                            state_next = S_RB_RD;
                        end
                        else if (flags.pos_gt_count || flags.pos_eq_count)
                        begin
                            cmd.status = ST_BADPOS;
                        end
                        else
                        begin
                            kind_next  = K_MID;
                            state_next = S_WSTART;
                        end
                    end
                    OP_SEARCH:
                    begin
                        state_next = S_WSTART;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CAP;
            end
            S_FREE_CAP:
            begin
                cmd.act = ACT_FREE_CAP;
                case (kind_reg)
                    K_FRONT: state_next = S_INS_F;
                    K_BACK:  state_next = S_INS_B;
                    default: state_next = S_WSTART;
                endcase
            end
            S_WSTART:
            begin
                cmd.act    = ACT_WSTART;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.act = ACT_WALK;
                if (flags.walk_done)
                begin
                    if (flags.op == OP_SEARCH)
                    begin
                        state_next = S_DONE;
                    end
                    else if (flags.op == OP_INS_POS)
                    begin
                        state_next = S_INS_M1;
                    end
                    else if (kind_reg == K_FRONT)
                    begin
                        state_next = S_REM_F;
                    end
                    else
                    begin
                        state_next = S_REM_M;
                    end
                end
            end
            S_INS_F:
            begin
                cmd.act    = ACT_INS_F;
                state_next = S_DONE;
            end
            S_INS_B:
            begin
                cmd.act    = ACT_INS_B;
                state_next = S_DONE;
            end
            S_INS_M1:
            begin
                cmd.act    = ACT_INS_M1;
                state_next = S_INS_M2;
            end
            S_INS_M2:
            begin
                cmd.act    = ACT_INS_M2;
                state_next = S_DONE;
            end
            S_REM_F:
            begin
                cmd.act    = ACT_REM_F;
                state_next = S_DONE;
            end
            S_RB_RD:
            begin
                cmd.act    = ACT_RB_RD;
                state_next = S_RB_CAP;
            end
            S_RB_CAP:
            begin
                cmd.act    = ACT_RB_CAP;
                state_next = S_DONE;
            end
            S_REM_M:
            begin
                cmd.act    = ACT_REM_M;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register can take the word.
                if (flags.out_free)
                begin
                    cmd.act    = ACT_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_FRONT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ----- rtl/bounded_ordered_list_engine_unit.sv -----
// Top level of the bounded ordered list engine: controller plus datapath.
// Depends on bole_pkg, bole_ctrl, bole_datapath.
//
// channel  | dir | fields (tdata, from bit 0 up)
// s_axis   | in  | operation[2:0] value[34:3] position[43:35]
// m_axis   | out | status[1:0] removed_value[33:2] found[34] element_count[43:35]
//
// One operation at a time: a new word is taken only while the controller is idle.
// Positional ops and search walk up to CAPACITY next-link slots, one slot per cycle.
// Result sits in an output register; the next word is taken while it waits.
// Reset is immediate: no memory clearing pass.
module bounded_ordered_list_engine_unit
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, value, position
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, removed_value, found, element_count
);

    cmd_t   cmd;
    flags_t flags;

    bole_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .flags(flags), .cmd(cmd)
    );

    bole_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .flags(flags), .in_data(s_tdata),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule

// ----- rtl/bole_checker.sv -----
// Port-level checker for the list engine, bound to the top level.
// Depends on bole_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bole_checker
    import bole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam logic [8:0] CAP_LOW = 9'(CAPACITY);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `ASSERT_NEXT(a_one_op, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken while an operation runs")
    `ASSERT_IMPL(a_found_ok, clk, rst_n, m_tvalid && m_tdata[34], m_tdata[1:0] == ST_OK,
        "found with error status")
    `ASSERT_IMPL(a_removed_ok, clk, rst_n, m_tvalid && (m_tdata[33:2] != '0),
        m_tdata[1:0] == ST_OK, "removed value with error status")
    `ASSERT_IMPL(a_full_count, clk, rst_n, m_tvalid && (m_tdata[1:0] == ST_FULL),
        m_tdata[43:35] == CAP_LOW, "full status with count below capacity")

endmodule

bind bounded_ordered_list_engine_unit bole_checker #(.CAPACITY(CAPACITY)) u_bole_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- dv/tb_bounded_ordered_list_engine_unit.sv -----
// Self-checking testbench for the bounded ordered list engine.
// Holds its own list predictor and drives random operations through the streams.
// Depends on bole_pkg and bounded_ordered_list_engine_unit.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine_unit;
    import bole_pkg::*;

    localparam int CAP = 256;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 3000000;

    // Highest field first, so status lands in the low bits.
    typedef struct packed {
        logic [8:0]  element_count;
        logic        found;
        logic [31:0] removed_value;
        logic [1:0]  status;
    } list_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;

    // Predicted list contents, front first.
    logic [31:0] list_values[$];
    list_result_t expected_results[$];

    int mismatches;
    int cycles;
    bit sink_idle_on;
    bit source_idle_on;
    bit sink_hold;

    bounded_ordered_list_engine_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic list_result_t apply_list_op(logic [2:0] op, logic [31:0] v,
                                                   logic [8:0] pos);
        list_result_t r;
        int n;
        n = list_values.size();
        r = '0;
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS:
            begin
                if (n >= CAP)
                    r.status = ST_FULL;
                else if (op == OP_INS_FRONT)
                    list_values.push_front(v);
                else if (op == OP_INS_BACK)
                    list_values.push_back(v);
                else if (pos > n)
                    r.status = ST_BADPOS;
                else
                    list_values.insert(pos, v);
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_POS:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (op == OP_REM_FRONT)
                    r.removed_value = list_values.pop_front();
                else if (op == OP_REM_BACK)
                    r.removed_value = list_values.pop_back();
                else if (pos >= n)
                    r.status = ST_BADPOS;
                else
                begin
                    r.removed_value = list_values[pos];
                    list_values.delete(pos);
                end
            end
            OP_SEARCH:
            begin
                foreach (list_values[i])
                    if (list_values[i] == v)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.element_count = 9'(list_values.size());
        return r;
    endfunction

    // Occasional idle bursts on the sender side.
    task automatic send_op(logic [2:0] op, logic [31:0] v, logic [8:0] pos);
        if (source_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tdata  <= {4'b0, pos, v, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(apply_list_op(op, v, pos));
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 15)) - 8);
            default: return $urandom();
        endcase
    endfunction

    // Positions mostly in range, sometimes just past the end or anywhere.
    function automatic logic [8:0] rand_pos(int bias);
        int n;
        n = list_values.size();
        case ($urandom_range(0, 9))
            0: return 9'($urandom_range(0, 511));
            1: return 9'(n + bias);
            default: return 9'($urandom_range(0, n));
        endcase
    endfunction

    function automatic logic [31:0] search_value();
        if (list_values.size() > 0 && $urandom_range(0, 1))
            return list_values[$urandom_range(0, list_values.size() - 1)];
        return rand_value();
    endfunction

    task automatic test_directed();
        send_op(OP_REM_FRONT, 32'h0, 9'd0);
        send_op(OP_REM_BACK, 32'h0, 9'd0);
        send_op(OP_REM_POS, 32'h0, 9'd3);
        send_op(OP_SEARCH, 32'h5, 9'd0);
        send_op(OP_INS_POS, 32'h1, 9'd1);
        send_op(OP_INS_POS, 32'h7FFF_FFFF, 9'd0);
        send_op(OP_INS_FRONT, 32'h8000_0000, 9'h1FF);
        send_op(OP_INS_BACK, 32'hFFFF_FFFF, 9'd0);
        send_op(OP_INS_POS, 32'h0000_0042, 9'd3);
        send_op(OP_INS_POS, 32'h0000_0013, 9'd2);
        send_op(OP_INS_POS, 32'h0000_0099, 9'd9);
        send_op(OP_SEARCH, 32'h0000_0013, 9'd0);
        send_op(OP_SEARCH, 32'h1234_5678, 9'd0);
        send_op(OP_UNUSED, 32'hFFFF_FFFF, 9'h1FF);
        send_op(OP_REM_POS, 32'h0, 9'd2);
        send_op(OP_REM_POS, 32'h0, 9'd3);
        send_op(OP_REM_POS, 32'h0, 9'd4);
        send_op(OP_REM_POS, 32'h0, 9'd0);
        send_op(OP_REM_BACK, 32'h0, 9'd0);
        send_op(OP_REM_FRONT, 32'h0, 9'd0);
        send_op(OP_REM_FRONT, 32'h0, 9'd0);
    endtask

    // Fill to capacity, poke the full cases, then drain.
    task automatic test_full_list();
        while (list_values.size() < CAP)
            send_op($urandom_range(0, 1) ? OP_INS_BACK : OP_INS_POS, rand_value(),
                    9'($urandom_range(0, list_values.size())));
        send_op(OP_INS_FRONT, 32'h1, 9'd0);
        send_op(OP_INS_BACK, 32'h1, 9'd0);
        send_op(OP_INS_POS, 32'h1, 9'h1FF);
        send_op(OP_SEARCH, list_values[CAP - 1], 9'd0);
        send_op(OP_SEARCH, 32'h7FFF_FFFE, 9'd0);
        send_op(OP_REM_POS, 32'h0, 9'd256);
        send_op(OP_REM_POS, 32'h0, 9'd255);
        while (list_values.size() > 0)
            send_op($urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_POS, 32'h0,
                    9'($urandom_range(0, list_values.size() - 1)));
    endtask

    // Random operations; the list size drifts between small and large.
    task automatic test_random(int n_items);
        logic [2:0] op;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                op = 3'($urandom_range(0, 7));
            else if ((i / 200) % 2 == 0)
                op = 3'($urandom_range(0, 9) < 6 ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 6));
            else
                op = 3'($urandom_range(0, 9) < 6 ? $urandom_range(3, 5)
                                                  : $urandom_range(0, 6));
            send_op(op, (op == OP_SEARCH) ? search_value() : rand_value(),
                    rand_pos(op == OP_REM_POS ? 0 : 1));
        end
    endtask

    // Long receiver hold-off while the sender keeps offering words.
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                sink_hold = 1'b0;
            end
        join_none
        test_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        sink_hold = 1'b0;
        sink_idle_on = 1'b1;
        source_idle_on = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random(500);
        test_full_list();
        test_random(520);
        sink_idle_on = 1'b0;
        source_idle_on = 1'b0;
        test_random(150);
        s_tvalid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver ready with random idle bursts.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold)
                m_tready <= 1'b0;
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[43:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %0d/%0d rem %h/%h found %0d/%0d cnt %0d/%0d",
                                 want.status, got.status, want.removed_value,
                                 got.removed_value, want.found, got.found,
                                 want.element_count, got.element_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
